// ----- hdl/ksup_pkg.sv -----
// shared types and constants for the key set update parser
`default_nettype none

package ksup_pkg;

  // parse phase, also the role code of bytes seen in that phase
  typedef enum logic [3:0] {
    PH_CTRL  = 4'd0,
    PH_REV   = 4'd1,
    PH_ACT   = 4'd2,
    PH_EXP   = 4'd3,
    PH_COUNT = 4'd4,
    PH_KID   = 4'd5,
    PH_KLEN  = 4'd6,
    PH_KDATA = 4'd7,
    PH_DONE  = 4'd8,
    PH_ERR   = 4'd9
  } phase_t;

  localparam logic [3:0] ROLE_CONTROL   = 4'd0;
  localparam logic [3:0] ROLE_KEY_COUNT = 4'd4;
  localparam logic [3:0] ROLE_TRAILING  = 4'd8;
  localparam logic [3:0] ROLE_AFTER_ERR = 4'd9;

  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_TRUNCATED = 2'd1;
  localparam logic [1:0] ERR_TOO_MANY  = 2'd2;
  localparam logic [1:0] ERR_KEY_LONG  = 2'd3;

  // control byte flag positions
  localparam int FLAG_S0_TIMES = 7;
  localparam int FLAG_S0_KEYS  = 6;
  localparam int FLAG_S1_TIMES = 4;
  localparam int FLAG_S1_KEYS  = 3;

  typedef struct packed {
    logic [7:0]  flag_bits;
    phase_t      phase;
    logic [1:0]  byte_in_field;
    logic        current_set;
    logic [7:0]  keys_left;
    logic [7:0]  key_bytes_left;
    logic [7:0]  entry_counter;
    logic [23:0] accumulator;
  } ksup_state_t;

  localparam ksup_state_t KSUP_RESET = '{
    flag_bits:      8'd0,
    phase:          PH_CTRL,
    byte_in_field:  2'd0,
    current_set:    1'b0,
    keys_left:      8'd0,
    key_bytes_left: 8'd0,
    entry_counter:  8'd0,
    accumulator:    24'd0
  };

  typedef struct packed {
    logic [3:0]  role;
    logic        set_index;
    logic [7:0]  entry_index;
    logic [31:0] field_value;
    logic        field_done;
    logic        message_done;
    logic [1:0]  error_code;
  } ksup_result_t;

endpackage

`default_nettype wire

// ----- hdl/ksup_step.sv -----
// one byte step of the parser: next state and result for the current byte
`default_nettype none

module ksup_step #(
  parameter int MAX_KEYS      = 32,
  parameter int MAX_KEY_BYTES = 64
) (
  input  ksup_pkg::ksup_state_t  cur,
  input  logic [7:0]             data_byte,
  input  logic                   is_last,
  output ksup_pkg::ksup_state_t  nxt,
  output ksup_pkg::ksup_result_t res
);
  import ksup_pkg::*;

  typedef struct packed {
    logic   set;
    phase_t phase;
  } pos_t;

  // first phase of set s (or a later set) given the flags
  function automatic pos_t enter_set(input logic [7:0] f, input logic s);
    pos_t p;
    if (!s && f[FLAG_S0_TIMES]) begin
      p = '{set: 1'b0, phase: PH_REV};
    end else if (!s && f[FLAG_S0_KEYS]) begin
      p = '{set: 1'b0, phase: PH_COUNT};
    end else if (f[FLAG_S1_TIMES]) begin
      p = '{set: 1'b1, phase: PH_REV};
    end else if (f[FLAG_S1_KEYS]) begin
      p = '{set: 1'b1, phase: PH_COUNT};
    end else begin
      p = '{set: 1'b1, phase: PH_DONE};
    end
    return p;
  endfunction

  localparam logic [7:0] KEY_LIMIT  = 8'(MAX_KEYS);
  localparam logic [7:0] BYTE_LIMIT = 8'(MAX_KEY_BYTES);

  ksup_state_t step;
  pos_t        ctrl_pos;
  pos_t        end_set_pos;
  pos_t        end_entry_pos;
  logic [7:0]  keys_dec;
  logic [7:0]  kbytes_dec;
  logic [7:0]  entry_inc;
  logic [2:0]  bif_inc;
  logic [23:0] acc_take;
  logic        cur_has_keys;
  logic        too_many;
  logic        too_long;

  assign ctrl_pos      = enter_set(data_byte, 1'b0);
  assign end_set_pos   = cur.current_set ? pos_t'{set: 1'b1, phase: PH_DONE}
                                         : enter_set(cur.flag_bits, 1'b1);
  assign keys_dec      = cur.keys_left - 8'd1;
  assign kbytes_dec    = cur.key_bytes_left - 8'd1;
  assign entry_inc     = cur.entry_counter + 8'd1;
  assign end_entry_pos = (keys_dec == 8'd0) ? end_set_pos
                                            : pos_t'{set: cur.current_set, phase: PH_KID};
  assign bif_inc       = {1'b0, cur.byte_in_field} + 3'd1;
  assign acc_take      = (cur.byte_in_field == 2'd0) ? {16'd0, data_byte}
                                                     : {cur.accumulator[15:0], data_byte};
  assign cur_has_keys  = cur.current_set ? cur.flag_bits[FLAG_S1_KEYS]
                                         : cur.flag_bits[FLAG_S0_KEYS];
  assign too_many      = data_byte > KEY_LIMIT;
  assign too_long      = data_byte > BYTE_LIMIT;

  // next state
  always_comb begin
    step = cur;
    unique case (cur.phase)
      PH_CTRL: begin
        step.flag_bits     = data_byte;
        step.entry_counter = 8'd0;
        step.current_set   = ctrl_pos.set;
        step.phase         = ctrl_pos.phase;
        step.byte_in_field = 2'd0;
      end
      PH_REV: begin
        step.phase         = PH_ACT;
        step.byte_in_field = 2'd0;
      end
      PH_ACT, PH_EXP: begin
        step.accumulator   = acc_take;
        step.byte_in_field = bif_inc[1:0];
        if (bif_inc == 3'd4) begin
          step.byte_in_field = 2'd0;
          if (cur.phase == PH_ACT) begin
            step.phase = PH_EXP;
          end else if (cur_has_keys) begin
            step.phase = PH_COUNT;
          end else begin
            step.current_set = end_set_pos.set;
            step.phase       = end_set_pos.phase;
          end
        end
      end
      PH_COUNT: begin
        step.byte_in_field = 2'd0;
        if (too_many) begin
          step.phase = PH_ERR;
        end else begin
          step.keys_left     = data_byte;
          step.entry_counter = 8'd0;
          if (data_byte == 8'd0) begin
            step.current_set = end_set_pos.set;
            step.phase       = end_set_pos.phase;
          end else begin
            step.phase = PH_KID;
          end
        end
      end
      PH_KID: begin
        step.accumulator   = acc_take;
        step.byte_in_field = bif_inc[1:0];
        if (bif_inc == 3'd2) begin
          step.byte_in_field = 2'd0;
          step.phase         = PH_KLEN;
        end
      end
      PH_KLEN: begin
        step.byte_in_field = 2'd0;
        if (too_long) begin
          step.phase = PH_ERR;
        end else begin
          step.key_bytes_left = data_byte;
          if (data_byte == 8'd0) begin
            step.entry_counter = entry_inc;
            step.keys_left     = keys_dec;
            step.current_set   = end_entry_pos.set;
            step.phase         = end_entry_pos.phase;
          end else begin
            step.phase = PH_KDATA;
          end
        end
      end
      PH_KDATA: begin
        step.key_bytes_left = kbytes_dec;
        if (kbytes_dec == 8'd0) begin
          step.entry_counter = entry_inc;
          step.keys_left     = keys_dec;
          step.current_set   = end_entry_pos.set;
          step.phase         = end_entry_pos.phase;
          step.byte_in_field = 2'd0;
        end
      end
      PH_DONE: begin
        step.phase = PH_DONE;
      end
      default: begin
        step.phase         = PH_ERR;
        step.byte_in_field = 2'd0;
      end
    endcase
  end

  // end of buffer always returns to the control byte
  assign nxt = is_last ? KSUP_RESET : step;

  // result of this byte
  always_comb begin
    logic active;
    res        = '0;
    active     = 1'b1;
    res.role   = cur.phase;
    unique case (cur.phase)
      PH_CTRL: begin
        res.field_done  = 1'b1;
        res.field_value = {24'd0, data_byte};
      end
      PH_REV: begin
        res.set_index   = cur.current_set;
        res.field_done  = 1'b1;
        res.field_value = {24'd0, data_byte};
      end
      PH_ACT, PH_EXP: begin
        res.set_index = cur.current_set;
        if (bif_inc == 3'd4) begin
          res.field_done  = 1'b1;
          res.field_value = {cur.accumulator, data_byte};
        end
      end
      PH_COUNT: begin
        res.set_index   = cur.current_set;
        res.field_done  = 1'b1;
        res.field_value = {24'd0, data_byte};
        if (too_many) begin
          res.error_code = ERR_TOO_MANY;
        end
      end
      PH_KID: begin
        res.set_index   = cur.current_set;
        res.entry_index = cur.entry_counter;
        if (bif_inc == 3'd2) begin
          res.field_done  = 1'b1;
          res.field_value = {16'd0, acc_take[15:0]};
        end
      end
      PH_KLEN: begin
        res.set_index   = cur.current_set;
        res.entry_index = cur.entry_counter;
        res.field_done  = 1'b1;
        res.field_value = {24'd0, data_byte};
        if (too_long) begin
          res.error_code = ERR_KEY_LONG;
        end
      end
      PH_KDATA: begin
        res.set_index   = cur.current_set;
        res.entry_index = cur.entry_counter;
        res.field_done  = 1'b1;
        res.field_value = {24'd0, data_byte};
      end
      PH_DONE: begin
        res.role = ROLE_TRAILING;
        active   = 1'b0;
      end
      default: begin
        res.role = ROLE_AFTER_ERR;
        active   = 1'b0;
      end
    endcase
    res.message_done = active && (step.phase == PH_DONE);
    if (is_last && active && (step.phase != PH_DONE) && (res.error_code == ERR_NONE)) begin
      res.error_code = ERR_TRUNCATED;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/key_set_update_parser_core.sv -----
// top level of the byte-serial update key set message parser
//
//  channel | signals                                   | dir | accepted when
//  --------+-------------------------------------------+-----+----------------------------
//  in      | in_valid, data_byte, is_last              | in  | in_valid && !in_stall
//  out     | out_valid, role, set_index, entry_index,  | out | out_valid && !out_stall
//          | field_value, field_done, message_done,    |     |
//          | error_code                                |     |
//
// one byte per cycle while in_stall is low; each accepted byte gives exactly one result transaction
// loaded into the output register, or held in the skid register while an earlier result is still stalled
// a two-entry output buffer (output register plus skid register) lets a new byte
// in while a result waits; in_stall rises only when both entries are full
// rst is synchronous: parser returns to expecting a control byte, buffer empties
// a byte with is_last set also returns the parser to its reset state
`default_nettype none

module key_set_update_parser_core #(
  parameter int MAX_KEYS      = 32,
  parameter int MAX_KEY_BYTES = 64
) (
  input  logic        clk,
  input  logic        rst,
  // byte input
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        is_last,
  // result output
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  role,
  output logic        set_index,
  output logic [7:0]  entry_index,
  output logic [31:0] field_value,
  output logic        field_done,
  output logic        message_done,
  output logic [1:0]  error_code
);
  import ksup_pkg::*;

  ksup_state_t  state;
  ksup_state_t  state_next;
  ksup_result_t step_res;
  ksup_result_t out_res;
  ksup_result_t skid_res;
  logic         skid_valid;
  logic         in_take;
  logic         out_free;

  // parser step logic
  ksup_step #(
    .MAX_KEYS      (MAX_KEYS),
    .MAX_KEY_BYTES (MAX_KEY_BYTES)
  ) u_step (
    .cur       (state),
    .data_byte (data_byte),
    .is_last   (is_last),
    .nxt       (state_next),
    .res       (step_res)
  );

  // stall only when the skid register is occupied
  assign in_stall = skid_valid;
  assign in_take  = in_valid && !skid_valid;
  // output register can load: empty, or its transaction completes this cycle
  assign out_free = !out_valid || !out_stall;

  // parser state and buffer occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= KSUP_RESET;
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (in_take) begin
        state <= state_next;
      end
      if (out_free) begin
        out_valid  <= skid_valid || in_take;
        skid_valid <= 1'b0;
      end else if (in_take) begin
        skid_valid <= 1'b1;
      end
    end
  end

  // result payload, oldest transaction first
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_res <= skid_res;
      end else if (in_take) begin
        out_res <= step_res;
      end
    end else if (in_take) begin
      skid_res <= step_res;
    end
  end

  assign role         = out_res.role;
  assign set_index    = out_res.set_index;
  assign entry_index  = out_res.entry_index;
  assign field_value  = out_res.field_value;
  assign field_done   = out_res.field_done;
  assign message_done = out_res.message_done;
  assign error_code   = out_res.error_code;

endmodule

`default_nettype wire

// ----- hdl/ksup_check.sv -----
// port-level checks for the key set update parser, bound to the top level
`default_nettype none

module ksup_check (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [3:0]  role,
  input logic [31:0] field_value,
  input logic        message_done,
  input logic [1:0]  error_code
);
  import ksup_pkg::*;

  logic out_take;
  logic seen;
  logic prev_trailing;
  logic prev_failed;

  assign out_take = out_valid && !out_stall;

  // role history of delivered results
  always_ff @(posedge clk) begin
    if (rst) begin
      seen          <= 1'b0;
      prev_trailing <= 1'b0;
      prev_failed   <= 1'b0;
    end else if (out_take) begin
      seen          <= 1'b1;
      prev_trailing <= (role == ROLE_TRAILING) || message_done;
      prev_failed   <= (role == ROLE_AFTER_ERR) || (error_code == ERR_TOO_MANY)
                       || (error_code == ERR_KEY_LONG);
    end
  end

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(role) && $stable(field_value)
      && $stable(error_code))
    else $error("stalled result changed");

  // input stalls only while a result is pending
  a_stall_pending: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with empty output");

  // after completion only trailing bytes or a new control byte
  a_after_done: assert property (@(posedge clk) disable iff (rst)
    out_take && seen && prev_trailing |-> role == ROLE_TRAILING || role == ROLE_CONTROL)
    else $error("parse continued after completion");

  // after an error only after-error bytes or a new control byte
  a_after_err: assert property (@(posedge clk) disable iff (rst)
    out_take && seen && prev_failed |-> role == ROLE_AFTER_ERR || role == ROLE_CONTROL)
    else $error("parse continued after error");

  // buffer is empty after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("buffer not empty after reset");

endmodule

bind key_set_update_parser_core ksup_check u_ksup_check (.*);

`default_nettype wire

// ----- tb/key_set_update_parser_core_tb.sv -----
// self-checking testbench for the update key set message parser core
`timescale 1ns / 100ps

module key_set_update_parser_core_tb;
  import ksup_pkg::*;

  localparam int MAX_KEYS      = 32;
  localparam int MAX_KEY_BYTES = 64;
  localparam int RANDOM_BYTES  = 700;
  localparam int QUIET_TAIL    = 80;      // last bytes go out with no idling
  localparam int HOLD_START    = 400;     // cycle count at which the long hold begins
  localparam int HOLD_CYCLES   = 300;
  localparam int DRAIN_CYCLES  = 10;
  localparam int CYCLE_LIMIT   = 200000;

  // message generator flavors
  localparam int MSG_CLEAN     = 0;
  localparam int MSG_TRUNCATED = 1;
  localparam int MSG_BAD       = 2;
  localparam int MSG_NOISE     = 3;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } msg_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        is_last = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  role;
  logic        set_index;
  logic [7:0]  entry_index;
  logic [31:0] field_value;
  logic        field_done;
  logic        message_done;
  logic [1:0]  error_code;

  // bytes still to be offered, and decoded results still to come back
  msg_byte_t    msg_bytes_q[$];
  ksup_result_t decoded_q[$];

  int mismatches    = 0;
  int bytes_sent    = 0;
  int results_seen  = 0;
  int msgs_complete = 0;
  int err_count[4]  = '{0, 0, 0, 0};
  int cycle_count   = 0;
  int send_gap      = 0;
  int stall_gap     = 0;
  int hold_left     = 0;
  bit hold_done     = 1'b0;
  logic hold_active = 1'b0;

  // decoder state mirrored by the testbench
  logic [7:0]  dec_flags = 8'h00;
  phase_t      dec_phase = PH_CTRL;
  logic [2:0]  dec_pos = 3'd0;
  logic        dec_set = 1'b0;
  logic [7:0]  dec_keys_left = 8'h00;
  logic [7:0]  dec_key_bytes_left = 8'h00;
  logic [7:0]  dec_entry = 8'h00;
  logic [31:0] dec_acc = 32'h0;

  always #5 clk = ~clk;

  key_set_update_parser_core #(
    .MAX_KEYS     (MAX_KEYS),
    .MAX_KEY_BYTES(MAX_KEY_BYTES)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .data_byte   (data_byte),
    .is_last     (is_last),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .role        (role),
    .set_index   (set_index),
    .entry_index (entry_index),
    .field_value (field_value),
    .field_done  (field_done),
    .message_done(message_done),
    .error_code  (error_code)
  );

  task automatic note_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------------
  // decoder prediction
  // ---------------------------------------------------------------------------

  function automatic bit set_has_times(input logic s);
    return s ? dec_flags[FLAG_S1_TIMES] : dec_flags[FLAG_S0_TIMES];
  endfunction

  function automatic bit set_has_keys(input logic s);
    return s ? dec_flags[FLAG_S1_KEYS] : dec_flags[FLAG_S0_KEYS];
  endfunction

  task automatic clear_decoder();
    dec_flags          = 8'h00;
    dec_phase          = PH_CTRL;
    dec_pos            = 3'd0;
    dec_set            = 1'b0;
    dec_keys_left      = 8'h00;
    dec_key_bytes_left = 8'h00;
    dec_entry          = 8'h00;
    dec_acc            = 32'h0;
  endtask

  task automatic goto_phase(input phase_t p);
    dec_phase = p;
    dec_pos   = 3'd0;
  endtask

  // pick the first present part of set s, falling through to set 1 or done
  task automatic open_set(input logic s);
    dec_set = s;
    if (set_has_times(s)) goto_phase(PH_REV);
    else if (set_has_keys(s)) goto_phase(PH_COUNT);
    else if (s) goto_phase(PH_DONE);
    else open_set(1'b1);
  endtask

  task automatic close_set();
    if (!dec_set) open_set(1'b1);
    else goto_phase(PH_DONE);
  endtask

  task automatic close_entry();
    dec_entry     = dec_entry + 8'd1;
    dec_keys_left = dec_keys_left - 8'd1;
    if (dec_keys_left == 8'd0) close_set();
    else goto_phase(PH_KID);
  endtask

  task automatic shift_in(input logic [7:0] b);
    if (dec_pos == 3'd0) dec_acc = {24'h0, b};
    else dec_acc = {dec_acc[23:0], b};
    dec_pos = dec_pos + 3'd1;
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic last, output ksup_result_t r);
    r      = '0;
    r.role = dec_phase;
    case (dec_phase)
      PH_CTRL: begin
        dec_flags     = b;
        r.field_done  = 1'b1;
        r.field_value = {24'h0, b};
        dec_entry     = 8'h00;
        open_set(1'b0);
      end
      PH_REV: begin
        r.set_index   = dec_set;
        r.field_done  = 1'b1;
        r.field_value = {24'h0, b};
        goto_phase(PH_ACT);
      end
      PH_ACT, PH_EXP: begin
        r.set_index = dec_set;
        shift_in(b);
        if (dec_pos >= 3'd4) begin
          r.field_done  = 1'b1;
          r.field_value = dec_acc;
          if (dec_phase == PH_ACT) goto_phase(PH_EXP);
          else if (set_has_keys(dec_set)) goto_phase(PH_COUNT);
          else close_set();
        end
      end
      PH_COUNT: begin
        r.set_index   = dec_set;
        r.field_done  = 1'b1;
        r.field_value = {24'h0, b};
        if (b > MAX_KEYS) begin
          r.error_code = ERR_TOO_MANY;
          goto_phase(PH_ERR);
        end else begin
          dec_keys_left = b;
          dec_entry     = 8'h00;
          if (b == 8'd0) close_set();
          else goto_phase(PH_KID);
        end
      end
      PH_KID: begin
        r.set_index   = dec_set;
        r.entry_index = dec_entry;
        shift_in(b);
        if (dec_pos >= 3'd2) begin
          r.field_done  = 1'b1;
          r.field_value = {16'h0, dec_acc[15:0]};
          goto_phase(PH_KLEN);
        end
      end
      PH_KLEN: begin
        r.set_index   = dec_set;
        r.entry_index = dec_entry;
        r.field_done  = 1'b1;
        r.field_value = {24'h0, b};
        if (b > MAX_KEY_BYTES) begin
          r.error_code = ERR_KEY_LONG;
          goto_phase(PH_ERR);
        end else begin
          dec_key_bytes_left = b;
          if (b == 8'd0) close_entry();
          else goto_phase(PH_KDATA);
        end
      end
      PH_KDATA: begin
        r.set_index        = dec_set;
        r.entry_index      = dec_entry;
        r.field_done       = 1'b1;
        r.field_value      = {24'h0, b};
        dec_key_bytes_left = dec_key_bytes_left - 8'd1;
        if (dec_key_bytes_left == 8'd0) close_entry();
      end
      PH_DONE: r.role = ROLE_TRAILING;
      default: begin
        r.role = ROLE_AFTER_ERR;
        goto_phase(PH_ERR);
      end
    endcase
    // a structure byte that lands the parser in done completes the message
    if (r.role < ROLE_TRAILING && dec_phase == PH_DONE) r.message_done = 1'b1;
    // end of buffer: flag truncation unless a harder error already fired
    if (last) begin
      if (r.role < ROLE_TRAILING && dec_phase != PH_DONE && r.error_code == ERR_NONE)
        r.error_code = ERR_TRUNCATED;
      clear_decoder();
    end
  endtask

  // ---------------------------------------------------------------------------
  // message generation
  // ---------------------------------------------------------------------------

  task automatic push_byte(input logic [7:0] d, input logic last);
    msg_bytes_q.push_back('{data: d, last: last});
  endtask

  // mostly short lists, now and then the full count or an illegal one
  function automatic int pick_key_count(input bit allow_bad);
    int r;
    r = $urandom_range(0, 99);
    if (allow_bad && r < 40) return $urandom_range(MAX_KEYS + 1, 255);
    if (r < 4) return MAX_KEYS;
    return $urandom_range(0, 3);
  endfunction

  function automatic int pick_key_len(input bit allow_bad);
    int r;
    r = $urandom_range(0, 99);
    if (allow_bad && r < 20) return $urandom_range(MAX_KEY_BYTES + 1, 255);
    if (r < 4) return MAX_KEY_BYTES;
    return $urandom_range(0, 6);
  endfunction

  task automatic add_message(input int flavor);
    logic [7:0] body[$];
    logic [7:0] ctrl;
    int         nkeys;
    int         klen;
    int         cut;
    int         extra;
    bit         stop;
    // noise: random bytes with random ends, closed by a final end mark to resync
    if (flavor == MSG_NOISE) begin
      repeat ($urandom_range(1, 12)) push_byte(8'($urandom), $urandom_range(0, 7) == 0);
      push_byte(8'($urandom), 1'b1);
      return;
    end
    ctrl = 8'($urandom);
    body.push_back(ctrl);
    stop = 1'b0;
    for (int s = 0; s < 2 && !stop; s++) begin
      if (ctrl[s ? FLAG_S1_TIMES : FLAG_S0_TIMES])
        repeat (9) body.push_back(8'($urandom));
      if (ctrl[s ? FLAG_S1_KEYS : FLAG_S0_KEYS]) begin
        nkeys = pick_key_count(flavor == MSG_BAD);
        body.push_back(8'(nkeys));
        if (nkeys > MAX_KEYS) stop = 1'b1;
        for (int k = 0; k < nkeys && !stop; k++) begin
          body.push_back(8'($urandom));
          body.push_back(8'($urandom));
          klen = pick_key_len(flavor == MSG_BAD);
          body.push_back(8'(klen));
          if (klen > MAX_KEY_BYTES) stop = 1'b1;
          else repeat (klen) body.push_back(8'($urandom));
        end
      end
    end
    if (flavor == MSG_TRUNCATED && body.size() > 1) begin
      cut  = $urandom_range(0, body.size() - 2);
      body = body[0:cut];
    end else begin
      // trailing or after-error bytes before the end mark
      extra = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 4);
      repeat (extra) body.push_back(8'($urandom));
    end
    foreach (body[i]) push_byte(body[i], i == body.size() - 1);
  endtask

  task automatic add_directed();
    // bare control byte with no optional parts, done on its own
    push_byte(8'h00, 1'b1);
    // clear/more/remove flags only, then trailing bytes
    push_byte(8'h27, 1'b0);
    push_byte(8'hff, 1'b0);
    push_byte(8'h00, 1'b1);
    // set 0 with revision, extreme times and an empty key list
    push_byte(8'hc0, 1'b0);
    push_byte(8'hff, 1'b0);
    repeat (4) push_byte(8'hff, 1'b0);
    repeat (4) push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b1);
    // set 1 key count above the limit, then a byte after the error
    push_byte(8'h08, 1'b0);
    push_byte(8'(MAX_KEYS + 1), 1'b0);
    push_byte(8'h5a, 1'b1);
    // empty key, then an oversized key length on the end byte
    push_byte(8'h40, 1'b0);
    push_byte(8'h02, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hff, 1'b0);
    push_byte(8'hff, 1'b0);
    push_byte(8'(MAX_KEY_BYTES + 1), 1'b1);
    // set 1 revision, then times cut short by the end of the buffer
    push_byte(8'h10, 1'b0);
    push_byte(8'h7e, 1'b1);
  endtask

  // ---------------------------------------------------------------------------
  // byte driver: predicts each accepted transaction, then offers the next one
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_bytes
    ksup_result_t predicted;
    msg_byte_t    nxt;
    logic         offer;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        decode_byte(data_byte, is_last, predicted);
        decoded_q.push_back(predicted);
        bytes_sent++;
        if (predicted.message_done) msgs_complete++;
        err_count[predicted.error_code]++;
      end
      // payload may only move when nothing is offered or the offer was just taken
      if (!in_valid || !in_stall) begin
        offer = 1'b0;
        if (send_gap > 0) begin
          send_gap--;
        end else if (msg_bytes_q.size() > QUIET_TAIL && $urandom_range(0, 19) == 0) begin
          // idle burst of random length, this cycle included
          send_gap = $urandom_range(0, 15);
        end else if (msg_bytes_q.size() > 0) begin
          nxt       = msg_bytes_q.pop_front();
          offer     = 1'b1;
          data_byte <= nxt.data;
          is_last   <= nxt.last;
        end
        in_valid <= offer;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // long receiver hold, counted in cycles, so the skid buffer fills and the
  // parser has to stall its input while bytes keep being offered
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : long_hold
    if (rst) begin
      hold_active <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      if (hold_left == 0) hold_active <= 1'b0;
    end else if (!hold_done && cycle_count >= HOLD_START) begin
      hold_left   = HOLD_CYCLES;
      hold_done   = 1'b1;
      hold_active <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor: field by field against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : check_results
    ksup_result_t want;
    logic         stall_next;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (decoded_q.size() == 0) begin
          note_mismatch("result transaction with no prediction waiting");
        end else begin
          want = decoded_q.pop_front();
          if (role !== want.role)
            note_mismatch($sformatf("result %0d role %0d, predicted %0d",
                                    results_seen, role, want.role));
          if (set_index !== want.set_index)
            note_mismatch($sformatf("result %0d set_index %0d, predicted %0d",
                                    results_seen, set_index, want.set_index));
          if (entry_index !== want.entry_index)
            note_mismatch($sformatf("result %0d entry_index %0d, predicted %0d",
                                    results_seen, entry_index, want.entry_index));
          if (field_value !== want.field_value)
            note_mismatch($sformatf("result %0d field_value %h, predicted %h",
                                    results_seen, field_value, want.field_value));
          if (field_done !== want.field_done)
            note_mismatch($sformatf("result %0d field_done %0d, predicted %0d",
                                    results_seen, field_done, want.field_done));
          if (message_done !== want.message_done)
            note_mismatch($sformatf("result %0d message_done %0d, predicted %0d",
                                    results_seen, message_done, want.message_done));
          if (error_code !== want.error_code)
            note_mismatch($sformatf("result %0d error_code %0d, predicted %0d",
                                    results_seen, error_code, want.error_code));
        end
        results_seen++;
      end
      // random stall bursts, none near the end of the run
      stall_next = 1'b0;
      if (stall_gap > 0) begin
        stall_gap--;
        stall_next = 1'b1;
      end else if (msg_bytes_q.size() > QUIET_TAIL && $urandom_range(0, 15) == 0) begin
        stall_gap  = $urandom_range(0, 15);
        stall_next = 1'b1;
      end
      out_stall <= stall_next || hold_active;
    end
  end

  // watchdog
  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("key_set_update_parser_core_tb: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus build, reset and end of run
  // ---------------------------------------------------------------------------
  initial begin : run_test
    int directed_n;
    int r;
    add_directed();
    directed_n = msg_bytes_q.size();
    // mostly well-formed messages with random content, the rest broken or noise
    while (msg_bytes_q.size() < directed_n + RANDOM_BYTES) begin
      r = $urandom_range(0, 99);
      if (r < 60) add_message(MSG_CLEAN);
      else if (r < 75) add_message(MSG_TRUNCATED);
      else if (r < 90) add_message(MSG_BAD);
      else add_message(MSG_NOISE);
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    // everything offered, taken and answered
    while (msg_bytes_q.size() != 0 || in_valid || decoded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (decoded_q.size() != 0)
      note_mismatch($sformatf("%0d predicted results never arrived", decoded_q.size()));
    $display("covered %0d bytes (%0d directed): %0d complete messages, %0d truncated,",
             bytes_sent, directed_n, msgs_complete, err_count[ERR_TRUNCATED]);
    $display("  %0d key count overflows, %0d oversized keys, %0d mismatches",
             err_count[ERR_TOO_MANY], err_count[ERR_KEY_LONG], mismatches);
    if (mismatches == 0) begin
      $display("key_set_update_parser_core_tb: PASS");
    end else begin
      $display("key_set_update_parser_core_tb: FAIL");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/ksup_pkg.sv
hdl/ksup_step.sv
hdl/key_set_update_parser_core.sv
hdl/ksup_check.sv
tb/key_set_update_parser_core_tb.sv
